// ===== rtl/vrp_pkg.sv =====
// shared constants, types and tables for the vertex rotate and project pipeline
package vrp_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int ANGLE_W = 16;
    localparam int NAXES = 3;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_W = 33;
    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 33'sd652032874;
    localparam logic signed [CORDIC_W-1:0] CORDIC_HALF = 33'sd32768;
    localparam int CORDIC_OUT_SHIFT = 16;

    localparam int CS_W = 16;
    localparam int COORD_W = 18;
    localparam int ROT_W = 36;
    localparam int ROT_SHIFT = 14;
    localparam logic signed [ROT_W-1:0] ROT_HALF = 36'sd8192;

    localparam int CAM_DIST = 100;
    localparam int DEPTH_W = 11;
    localparam int DEPTH_SHIFT = 8;
    localparam int NUM_W = 43;
    localparam int DIV_SHIFT = 20;
    localparam int DIV_NW = 22;
    localparam int DIV_DW = 10;

    localparam int SCREEN_W = 16;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
        logic [1:0]                 quad;
    } cordic_lane_t;

    typedef struct packed {
        logic [DIV_NW-1:0] n;
        logic [DIV_DW-1:0] d;
        logic [DIV_DW-1:0] r;
        logic [DIV_NW-1:0] q;
        logic              neg;
    } div_lane_t;

    function automatic logic signed [CORDIC_W-1:0] atan_turn(input int step);
        logic signed [CORDIC_W-1:0] a;
        case (step)
            0:       a = 33'sh020000000;
            1:       a = 33'sh012E4051D;
            2:       a = 33'sh009FB385B;
            3:       a = 33'sh0051111D4;
            4:       a = 33'sh0028B0D43;
            5:       a = 33'sh00145D7E1;
            6:       a = 33'sh000A2F61E;
            7:       a = 33'sh000517C55;
            8:       a = 33'sh00028BE53;
            9:       a = 33'sh000145F2E;
            10:      a = 33'sh0000A2F98;
            11:      a = 33'sh0000517CC;
            12:      a = 33'sh000028BE6;
            13:      a = 33'sh0000145F3;
            14:      a = 33'sh00000A2F9;
            15:      a = 33'sh00000517C;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/vertex_rotate_project_core.sv =====
// top level: euler xyz rotation and perspective projection of one vertex per clock
// pipeline stages: 16 cordic cells, sin/cos rounding, three rotation stages, four projection
// stages, 22 divider cells, output register
// throughput: one vertex per cycle; the whole chain holds while a result waits on out_stall
// reset: only the stage valid bits clear, no result is pending after reset
module vertex_rotate_project_core #(
    parameter int SINE_TABLE_BITS = vrp_pkg::SINE_TABLE_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  vertex_x,
    input  logic signed [15:0]  vertex_y,
    input  logic signed [15:0]  vertex_z,
    input  logic [15:0]         angle_about_x,
    input  logic [15:0]         angle_about_y,
    input  logic [15:0]         angle_about_z,
    input  logic [14:0]         zoom_factor,
    input  logic signed [11:0]  offset_x,
    input  logic signed [11:0]  offset_y,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  screen_x,
    output logic signed [15:0]  screen_y,
    output logic                depth_fault
);

    localparam int AW = vrp_pkg::ANGLE_W;
    localparam int CW = vrp_pkg::CORDIC_W;
    localparam int SW = vrp_pkg::CS_W;
    localparam int XW = vrp_pkg::COORD_W;
    localparam int RW = vrp_pkg::ROT_W;
    localparam int DW = vrp_pkg::DEPTH_W;
    localparam int NW = vrp_pkg::NUM_W;
    localparam int STEPS = vrp_pkg::CORDIC_STEPS;
    localparam int NAX = vrp_pkg::NAXES;
    localparam int QN = vrp_pkg::DIV_NW;
    localparam int QD = vrp_pkg::DIV_DW;
    localparam int OW = vrp_pkg::SCREEN_W;
    localparam int XM_W = XW + 7;
    localparam int OFFD_W = 12 + DW;
    localparam int ZT_W = XW + 1;

    localparam int DROP = AW - SINE_TABLE_BITS;
    localparam logic [AW-1:0] ANGLE_MASK = AW'({AW{1'b1}} << DROP);

    localparam int Q_STG = STEPS;
    localparam int NSTG = STEPS + 9 + QN;

    localparam logic [1:0] QUAD_I = 2'd0;
    localparam logic [1:0] QUAD_II = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;
    localparam logic [1:0] QUAD_IV = 2'd3;

    localparam logic signed [ZT_W-1:0] CAM_Q8 = ZT_W'(vrp_pkg::CAM_DIST * 256);
    localparam logic signed [SW-1:0] CS_LIM = 16'sd16400;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        logic [14:0]        zoom;
        logic signed [11:0] offx;
        logic signed [11:0] offy;
    } side_t;

    function automatic logic signed [XW-1:0] rot_term(
        input logic signed [XW-1:0] a,
        input logic signed [XW-1:0] b,
        input logic signed [SW-1:0] ca,
        input logic signed [SW-1:0] cb
    );
        logic signed [RW-1:0] acc;
        acc = RW'(a) * RW'(ca) + RW'(b) * RW'(cb) + vrp_pkg::ROT_HALF;
        return XW'(acc >>> vrp_pkg::ROT_SHIFT);
    endfunction

    function automatic logic [OW-1:0] saturate(input logic [QN-1:0] q, input logic neg);
        logic [OW-1:0] r;
        logic [OW-1:0] qn;
        qn = -q[OW-1:0];
        if (!neg)
        begin
            r = (q > QN'(32767)) ? 16'h7FFF : q[OW-1:0];
        end
        else
        begin
            r = (q > QN'(32768)) ? 16'h8000 : qn;
        end
        return r;
    endfunction

    // pipeline control
    logic [NSTG-1:0] vld_reg;
    logic            adv;

    assign adv = !(vld_reg[NSTG-1] && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    // cordic chain
    vrp_pkg::cordic_lane_t [NAX-1:0] cchain [STEPS+1];
    logic [AW-1:0] ang [NAX];

    assign ang[0] = angle_about_x & ANGLE_MASK;
    assign ang[1] = angle_about_y & ANGLE_MASK;
    assign ang[2] = angle_about_z & ANGLE_MASK;

    always_comb
    begin
        for (int k = 0; k < NAX; k++)
        begin
            cchain[0][k].x    = vrp_pkg::CORDIC_X0;
            cchain[0][k].y    = '0;
            cchain[0][k].z    = CW'({ang[k][AW-3:0], 16'b0});
            cchain[0][k].quad = ang[k][AW-1:AW-2];
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cordic
        vrp_cordic_cell #(
            .STEP (i)
        ) u_cell (
            .clk      (clk),
            .adv      (adv),
            .lane_in  (cchain[i]),
            .lane_out (cchain[i+1])
        );
    end

    side_t side_reg [STEPS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= '{vertex_x, vertex_y, vertex_z, zoom_factor, offset_x, offset_y};
            for (int i = 1; i < STEPS; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // sin/cos rounding and quadrant mapping
    logic signed [SW-1:0] q_cos_reg [NAX];
    logic signed [SW-1:0] q_sin_reg [NAX];
    logic signed [SW-1:0] q_cos_next [NAX];
    logic signed [SW-1:0] q_sin_next [NAX];
    side_t                q_side_reg;

    always_comb
    begin
        logic signed [CW-1:0] xr;
        logic signed [CW-1:0] yr;
        logic signed [SW-1:0] cq;
        logic signed [SW-1:0] sq;
        for (int k = 0; k < NAX; k++)
        begin
            xr = ($signed(cchain[STEPS][k].x) + vrp_pkg::CORDIC_HALF) >>> vrp_pkg::CORDIC_OUT_SHIFT;
            yr = ($signed(cchain[STEPS][k].y) + vrp_pkg::CORDIC_HALF) >>> vrp_pkg::CORDIC_OUT_SHIFT;
            cq = SW'(xr);
            sq = SW'(yr);
            case (cchain[STEPS][k].quad)
                QUAD_I:
                begin
                    q_cos_next[k] = cq;
                    q_sin_next[k] = sq;
                end
                QUAD_II:
                begin
                    q_cos_next[k] = -sq;
                    q_sin_next[k] = cq;
                end
                QUAD_III:
                begin
                    q_cos_next[k] = -cq;
                    q_sin_next[k] = -sq;
                end
                QUAD_IV:
                begin
                    q_cos_next[k] = sq;
                    q_sin_next[k] = -cq;
                end
                default:
                begin
                    q_cos_next[k] = cq;
                    q_sin_next[k] = sq;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_cos_reg  <= q_cos_next;
            q_sin_reg  <= q_sin_next;
            q_side_reg <= side_reg[STEPS-1];
        end
    end

    // rotation about x, then y, then z
    logic signed [XW-1:0] r1_x_reg, r1_y_reg, r1_z_reg;
    logic signed [XW-1:0] r2_x_reg, r2_y_reg, r2_z_reg;
    logic signed [XW-1:0] r3_x_reg, r3_y_reg, r3_z_reg;
    logic signed [SW-1:0] r1_cy_reg, r1_sy_reg, r1_cz_reg, r1_sz_reg;
    logic signed [SW-1:0] r2_cz_reg, r2_sz_reg;
    logic [14:0]          r1_zoom_reg, r2_zoom_reg, r3_zoom_reg;
    logic signed [11:0]   r1_offx_reg, r2_offx_reg, r3_offx_reg;
    logic signed [11:0]   r1_offy_reg, r2_offy_reg, r3_offy_reg;
    logic signed [XW-1:0] q_vx, q_vy, q_vz;

    assign q_vx = XW'(q_side_reg.vx);
    assign q_vy = XW'(q_side_reg.vy);
    assign q_vz = XW'(q_side_reg.vz);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_x_reg    <= q_vx;
            r1_y_reg    <= rot_term(q_vy, q_vz, q_cos_reg[0], q_sin_reg[0]);
            r1_z_reg    <= rot_term(q_vz, q_vy, q_cos_reg[0], -q_sin_reg[0]);
            r1_cy_reg   <= q_cos_reg[1];
            r1_sy_reg   <= q_sin_reg[1];
            r1_cz_reg   <= q_cos_reg[2];
            r1_sz_reg   <= q_sin_reg[2];
            r1_zoom_reg <= q_side_reg.zoom;
            r1_offx_reg <= q_side_reg.offx;
            r1_offy_reg <= q_side_reg.offy;

            r2_z_reg    <= rot_term(r1_z_reg, r1_x_reg, r1_cy_reg, r1_sy_reg);
            r2_x_reg    <= rot_term(r1_x_reg, r1_z_reg, r1_cy_reg, -r1_sy_reg);
            r2_y_reg    <= r1_y_reg;
            r2_cz_reg   <= r1_cz_reg;
            r2_sz_reg   <= r1_sz_reg;
            r2_zoom_reg <= r1_zoom_reg;
            r2_offx_reg <= r1_offx_reg;
            r2_offy_reg <= r1_offy_reg;

            r3_x_reg    <= rot_term(r2_x_reg, r2_y_reg, r2_cz_reg, r2_sz_reg);
            r3_y_reg    <= rot_term(r2_y_reg, r2_x_reg, r2_cz_reg, -r2_sz_reg);
            r3_z_reg    <= r2_z_reg;
            r3_zoom_reg <= r2_zoom_reg;
            r3_offx_reg <= r2_offx_reg;
            r3_offy_reg <= r2_offy_reg;
        end
    end

    // projection: depth, scaling products, numerators, sign and magnitude
    logic signed [ZT_W-1:0]   zt;
    logic signed [DW-1:0]     d_next;
    logic signed [DW-1:0]     p1_d_reg, p2_d_reg, p3_d_reg;
    logic signed [XW-1:0]     p1_x_reg, p1_y_reg;
    logic [14:0]              p1_zoom_reg, p2_zoom_reg;
    logic signed [11:0]       p1_offx_reg, p1_offy_reg;
    logic signed [XM_W-1:0]   p2_xm_reg, p2_ym_reg;
    logic signed [OFFD_W-1:0] p2_offxd_reg, p2_offyd_reg;
    logic signed [NW-1:0]     p3_numx_reg, p3_numy_reg;
    logic signed [NW-1:0]     zoom_ext;
    logic [NW-1:0]            magx, magy;
    logic [DW-1:0]            dmag;
    vrp_pkg::div_lane_t [1:0] p4_lane_next;
    logic                     p4_fault_reg;

    assign zt = ZT_W'(r3_z_reg) - CAM_Q8;

    always_comb
    begin
        d_next = DW'(zt >>> vrp_pkg::DEPTH_SHIFT);
        if (zt[ZT_W-1] && (zt[vrp_pkg::DEPTH_SHIFT-1:0] != '0))
        begin
            d_next = d_next + DW'(1);
        end
    end

    assign zoom_ext = NW'($signed({1'b0, p2_zoom_reg}));
    assign magx = p3_numx_reg[NW-1] ? NW'(-p3_numx_reg) : NW'(p3_numx_reg);
    assign magy = p3_numy_reg[NW-1] ? NW'(-p3_numy_reg) : NW'(p3_numy_reg);
    assign dmag = p3_d_reg[DW-1] ? DW'(-p3_d_reg) : DW'(p3_d_reg);

    always_comb
    begin
        p4_lane_next[0].n   = QN'(magx >> vrp_pkg::DIV_SHIFT);
        p4_lane_next[0].d   = QD'(dmag);
        p4_lane_next[0].r   = '0;
        p4_lane_next[0].q   = '0;
        p4_lane_next[0].neg = p3_numx_reg[NW-1] ^ p3_d_reg[DW-1];
        p4_lane_next[1].n   = QN'(magy >> vrp_pkg::DIV_SHIFT);
        p4_lane_next[1].d   = QD'(dmag);
        p4_lane_next[1].r   = '0;
        p4_lane_next[1].q   = '0;
        p4_lane_next[1].neg = p3_numy_reg[NW-1] ^ p3_d_reg[DW-1];
    end

    vrp_pkg::div_lane_t [1:0] dchain [QN+1];
    logic                     fault_reg [QN];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_d_reg     <= d_next;
            p1_x_reg     <= r3_x_reg;
            p1_y_reg     <= r3_y_reg;
            p1_zoom_reg  <= r3_zoom_reg;
            p1_offx_reg  <= r3_offx_reg;
            p1_offy_reg  <= r3_offy_reg;

            p2_xm_reg    <= XM_W'(p1_x_reg) * $signed(XM_W'(vrp_pkg::CAM_DIST));
            p2_ym_reg    <= XM_W'(p1_y_reg) * $signed(XM_W'(vrp_pkg::CAM_DIST));
            p2_offxd_reg <= OFFD_W'(p1_offx_reg) * OFFD_W'(p1_d_reg);
            p2_offyd_reg <= OFFD_W'(p1_offy_reg) * OFFD_W'(p1_d_reg);
            p2_d_reg     <= p1_d_reg;
            p2_zoom_reg  <= p1_zoom_reg;

            p3_numx_reg  <= NW'(p2_xm_reg) * zoom_ext + (NW'(p2_offxd_reg) <<< vrp_pkg::DIV_SHIFT);
            p3_numy_reg  <= NW'(p2_ym_reg) * zoom_ext + (NW'(p2_offyd_reg) <<< vrp_pkg::DIV_SHIFT);
            p3_d_reg     <= p2_d_reg;

            dchain[0]    <= p4_lane_next;
            p4_fault_reg <= (p3_d_reg == '0);

            fault_reg[0] <= p4_fault_reg;
            for (int i = 1; i < QN; i++)
            begin
                fault_reg[i] <= fault_reg[i-1];
            end
        end
    end

    // divider chain, most significant quotient bit first
    for (genvar j = 0; j < QN; j++)
    begin : g_div
        vrp_div_cell #(
            .BIT (QN - 1 - j)
        ) u_cell (
            .clk      (clk),
            .adv      (adv),
            .lane_in  (dchain[j]),
            .lane_out (dchain[j+1])
        );
    end

    // output register
    logic [OW-1:0] screen_x_reg;
    logic [OW-1:0] screen_y_reg;
    logic          depth_fault_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            depth_fault_reg <= fault_reg[QN-1];
            if (fault_reg[QN-1])
            begin
                screen_x_reg <= '0;
                screen_y_reg <= '0;
            end
            else
            begin
                screen_x_reg <= saturate(dchain[QN][0].q, dchain[QN][0].neg);
                screen_y_reg <= saturate(dchain[QN][1].q, dchain[QN][1].neg);
            end
        end
    end

    assign out_valid   = vld_reg[NSTG-1];
    assign screen_x    = $signed(screen_x_reg);
    assign screen_y    = $signed(screen_y_reg);
    assign depth_fault = depth_fault_reg;

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && depth_fault |-> screen_x == '0 && screen_y == '0)
        else $error("depth fault transaction with nonzero screen position");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result waiting");

    a_result_leaves_taken: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("result dropped while stalled");

    for (genvar k = 0; k < NAX; k++)
    begin : g_cs_chk
        a_cs_bound: assert property (@(posedge clk) disable iff (!rst_n)
            vld_reg[Q_STG] |-> q_cos_reg[k] <= CS_LIM && q_cos_reg[k] >= -CS_LIM &&
                               q_sin_reg[k] <= CS_LIM && q_sin_reg[k] >= -CS_LIM)
            else $error("sine or cosine out of range");
    end

endmodule

// ===== rtl/vrp_cordic_cell.sv =====
// one cordic micro-rotation step for the three angle lanes
module vrp_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                                              clk,
    input  logic                                              adv,
    input  vrp_pkg::cordic_lane_t [vrp_pkg::NAXES-1:0]        lane_in,
    output vrp_pkg::cordic_lane_t [vrp_pkg::NAXES-1:0]        lane_out
);

    localparam logic signed [vrp_pkg::CORDIC_W-1:0] ATAN = vrp_pkg::atan_turn(STEP);

    vrp_pkg::cordic_lane_t [vrp_pkg::NAXES-1:0] lane_reg;
    vrp_pkg::cordic_lane_t [vrp_pkg::NAXES-1:0] lane_next;

    always_comb
    begin
        logic signed [vrp_pkg::CORDIC_W-1:0] dx;
        logic signed [vrp_pkg::CORDIC_W-1:0] dy;
        lane_next = lane_in;
        for (int k = 0; k < vrp_pkg::NAXES; k++)
        begin
            dx = $signed(lane_in[k].y) >>> STEP;
            dy = $signed(lane_in[k].x) >>> STEP;
            if (lane_in[k].z[vrp_pkg::CORDIC_W-1] == 1'b0)
            begin
                lane_next[k].x = $signed(lane_in[k].x) - dx;
                lane_next[k].y = $signed(lane_in[k].y) + dy;
                lane_next[k].z = $signed(lane_in[k].z) - ATAN;
            end
            else
            begin
                lane_next[k].x = $signed(lane_in[k].x) + dx;
                lane_next[k].y = $signed(lane_in[k].y) - dy;
                lane_next[k].z = $signed(lane_in[k].z) + ATAN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

// ===== rtl/vrp_div_cell.sv =====
// one restoring division step producing one quotient bit for both screen lanes
module vrp_div_cell #(
    parameter int BIT = 0
) (
    input  logic                          clk,
    input  logic                          adv,
    input  vrp_pkg::div_lane_t [1:0]      lane_in,
    output vrp_pkg::div_lane_t [1:0]      lane_out
);

    vrp_pkg::div_lane_t [1:0] lane_reg;
    vrp_pkg::div_lane_t [1:0] lane_next;

    always_comb
    begin
        logic [vrp_pkg::DIV_DW:0] rem_sh;
        logic [vrp_pkg::DIV_DW:0] rem_sub;
        lane_next = lane_in;
        for (int k = 0; k < 2; k++)
        begin
            rem_sh  = {lane_in[k].r, lane_in[k].n[BIT]};
            rem_sub = rem_sh - {1'b0, lane_in[k].d};
            if (rem_sh >= {1'b0, lane_in[k].d})
            begin
                lane_next[k].r      = rem_sub[vrp_pkg::DIV_DW-1:0];
                lane_next[k].q[BIT] = 1'b1;
            end
            else
            begin
                lane_next[k].r      = rem_sh[vrp_pkg::DIV_DW-1:0];
                lane_next[k].q[BIT] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

// ===== tb/vertex_rotate_project_core_tb.sv =====
// self-checking testbench for the vertex rotate and project core
module vertex_rotate_project_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAB_BITS = vrp_pkg::SINE_TABLE_BITS;
    localparam int RANDOM_ITEMS = 1800;
    localparam int LATENCY = 47;
    localparam longint CYCLE_LIMIT = 400000;
    localparam int NDIRECTED = 14;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        logic [15:0]        ax;
        logic [15:0]        ay;
        logic [15:0]        az;
        logic [14:0]        zoom;
        logic signed [11:0] offx;
        logic signed [11:0] offy;
    } vertex_t;

    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic               fault;
    } pixel_t;

    typedef struct packed {
        vertex_t v;
        logic    known;
        pixel_t  p;
    } vector_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [15:0] vertex_x, vertex_y, vertex_z;
    logic [15:0] angle_about_x, angle_about_y, angle_about_z;
    logic [14:0] zoom_factor;
    logic signed [11:0] offset_x, offset_y;
    logic out_valid;
    logic out_stall;
    logic signed [15:0] screen_x, screen_y;
    logic depth_fault;

    pixel_t pending_pixels[$];
    int mismatches;
    longint cycles;
    bit sending_done;
    logic long_hold;
    logic rx_stall;

    assign out_stall = rx_stall || long_hold;

    vertex_rotate_project_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
        .angle_about_x(angle_about_x), .angle_about_y(angle_about_y),
        .angle_about_z(angle_about_z), .zoom_factor(zoom_factor),
        .offset_x(offset_x), .offset_y(offset_y),
        .out_valid(out_valid), .out_stall(out_stall),
        .screen_x(screen_x), .screen_y(screen_y), .depth_fault(depth_fault)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint arctan_step(int i);
        case (i)
            0: return 64'h20000000;
            1: return 64'h12E4051D;
            2: return 64'h09FB385B;
            3: return 64'h051111D4;
            4: return 64'h028B0D43;
            5: return 64'h0145D7E1;
            6: return 64'h00A2F61E;
            7: return 64'h00517C55;
            8: return 64'h0028BE53;
            9: return 64'h00145F2E;
            10: return 64'h000A2F98;
            11: return 64'h000517CC;
            12: return 64'h00028BE6;
            13: return 64'h000145F3;
            14: return 64'h0000A2F9;
            default: return 64'h0000517C;
        endcase
    endfunction

    function automatic void angle_sin_cos(input logic [15:0] ang, output longint c,
                                          output longint s);
        logic [15:0] a;
        longint x, y, z, dx, dy, cq, sq;
        a = ang & ~16'((1 << (16 - TAB_BITS)) - 1);
        x = 652032874;
        y = 0;
        z = longint'(a[13:0]) << 16;
        for (int i = 0; i < 16; i++)
        begin
            dx = asr(y, i);
            dy = asr(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= arctan_step(i);
            end
            else
            begin
                x += dx; y -= dy; z += arctan_step(i);
            end
        end
        cq = asr(x + 32768, 16);
        sq = asr(y + 32768, 16);
        case (a[15:14])
            2'd0: begin c = cq;  s = sq;  end
            2'd1: begin c = -sq; s = cq;  end
            2'd2: begin c = -cq; s = -sq; end
            default: begin c = sq; s = -cq; end
        endcase
    endfunction

    function automatic void rotate_plane(inout longint a, inout longint b,
                                         input logic [15:0] ang);
        longint c, s, na;
        angle_sin_cos(ang, c, s);
        na = asr(a * c + b * s + 8192, 14);
        b = asr(-a * s + b * c + 8192, 14);
        a = na;
    endfunction

    function automatic logic signed [15:0] perspective(longint coord, longint zoom,
                                                        longint off, longint d);
        longint den, num, q;
        den = d * (longint'(1) << 20);
        num = coord * 100 * zoom + off * den;
        if (den < 0)
        begin
            den = -den;
            num = -num;
        end
        q = num / den;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function automatic pixel_t project_vertex(vertex_t v);
        pixel_t p;
        longint x, y, z, d;
        x = v.vx; y = v.vy; z = v.vz;
        rotate_plane(y, z, v.ax);
        rotate_plane(z, x, v.ay);
        rotate_plane(x, y, v.az);
        d = (z - 25600) / 256;
        if (d == 0)
            p = '{sx: 16'sd0, sy: 16'sd0, fault: 1'b1};
        else
            p = '{sx: perspective(x, v.zoom, v.offx, d),
                  sy: perspective(y, v.zoom, v.offy, d), fault: 1'b0};
        return p;
    endfunction

    function automatic vertex_t random_vertex();
        vertex_t v;
        v.vx = 16'($urandom);
        v.vy = 16'($urandom);
        v.vz = 16'($urandom);
        v.ax = 16'($urandom);
        v.ay = 16'($urandom);
        v.az = 16'($urandom);
        v.zoom = 15'($urandom);
        v.offx = 12'($urandom);
        v.offy = 12'($urandom);
        if ($urandom_range(3) == 0)
        begin
            v.vz = 16'(25600 + $urandom_range(511) - 255);
            v.ax = 0; v.ay = 0;
        end
        else if ($urandom_range(3) == 0)
        begin
            v.vx = 16'($urandom_range(4095) - 2048);
            v.vy = 16'($urandom_range(4095) - 2048);
            v.vz = 16'($urandom_range(4095) - 2048);
        end
        return v;
    endfunction

    task automatic send_vertex(vertex_t v);
        int idle;
        idle = $urandom_range(15);
        if (idle > 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid <= 1'b1;
        {vertex_x, vertex_y, vertex_z, angle_about_x, angle_about_y, angle_about_z,
         zoom_factor, offset_x, offset_y} <= v;
        pending_pixels.insert(pending_pixels.size(), project_vertex(v));
        do @(posedge clk); while (in_stall);
    endtask

    vector_row_t vectors[NDIRECTED];

    initial
    begin
        vectors[0]  = '{'{16'sd0, 16'sd0, 16'sd0, 16'd0, 16'd0, 16'd0, 15'd4096, 12'sd0, 12'sd0},
                       1'b1, '{16'sd0, 16'sd0, 1'b0}};
        vectors[1]  = '{'{16'sd0, 16'sd0, 16'sd25600, 16'd0, 16'd0, 16'd0, 15'd4096,
                          12'sd5, -12'sd7}, 1'b1, '{16'sd0, 16'sd0, 1'b1}};
        vectors[2]  = '{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'd0, 16'd0, 16'd0, 15'd0,
                          12'sd2047, -12'sd2048}, 1'b1, '{16'sd2047, -16'sd2048, 1'b0}};
        vectors[3]  = '{'{-16'sd32768, -16'sd32768, -16'sd32768, 16'hffff, 16'hffff,
                          16'hffff, 15'h7fff, -12'sd2048, 12'sd2047}, 1'b0, '0};
        vectors[4]  = '{'{16'sh7fff, -16'sd32768, 16'sd25700, 16'd0, 16'd0, 16'd0,
                          15'h7fff, 12'sd0, 12'sd0}, 1'b0, '0};
        vectors[5]  = '{'{16'sd256, 16'sd512, 16'sd768, 16'h4000, 16'd0, 16'd0, 15'd4096,
                          12'sd0, 12'sd0}, 1'b0, '0};
        vectors[6]  = '{'{16'sd256, 16'sd512, 16'sd768, 16'd0, 16'h8000, 16'd0, 15'd4096,
                          12'sd0, 12'sd0}, 1'b0, '0};
        vectors[7]  = '{'{16'sd256, 16'sd512, 16'sd768, 16'd0, 16'd0, 16'hc000, 15'd4096,
                          12'sd0, 12'sd0}, 1'b0, '0};
        vectors[8]  = '{'{16'sd1000, -16'sd1000, 16'sd25599, 16'h003f, 16'h0040, 16'h2000,
                          15'd8192, 12'sd10, 12'sd10}, 1'b0, '0};
        vectors[9]  = '{'{16'sd1000, -16'sd1000, 16'sd25856, 16'd0, 16'd0, 16'd0,
                          15'h7fff, -12'sd1, 12'sd1}, 1'b0, '0};
        vectors[10] = '{'{-16'sd5, 16'sd5, 16'sd25345, 16'h1234, 16'h5678, 16'h9abc,
                          15'h5555, 12'sh555, 12'shaaa}, 1'b0, '0};
        vectors[11] = '{'{16'sh5555, 16'shaaaa, 16'sh5555, 16'haaaa, 16'h5555, 16'haaaa,
                          15'h2aaa, 12'shaaa, 12'sh555}, 1'b0, '0};
        vectors[12] = '{'{16'sd0, 16'sd0, 16'sd0, 16'd0, 16'd0, 16'd0, 15'd0,
                          -12'sd2048, 12'sd2047}, 1'b1, '{-16'sd2048, 16'sd2047, 1'b0}};
        vectors[13] = '{'{16'sd100, 16'sd100, -16'sd25600, 16'h8000, 16'd0, 16'd0,
                          15'd4096, 12'sd0, 12'sd0}, 1'b1, '{16'sd0, 16'sd0, 1'b1}};

        rst_n = 1'b0;
        in_valid = 1'b0;
        {vertex_x, vertex_y, vertex_z, angle_about_x, angle_about_y, angle_about_z,
         zoom_factor, offset_x, offset_y} = '0;
        sending_done = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vectors[i])
        begin
            if (vectors[i].known && project_vertex(vectors[i].v) != vectors[i].p)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("directed row %0d: expected %h, predicted %h", i,
                             vectors[i].p, project_vertex(vectors[i].v));
            end
            send_vertex(vectors[i].v);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_vertex(random_vertex());
        in_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // downstream side: a random wait before every transaction
    initial
    begin
        int hold_cycles;
        rx_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            hold_cycles = $urandom_range(15);
            if (hold_cycles > 0)
            begin
                rx_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
            end
            rx_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // one long hold to fill the pipeline
    initial
    begin
        long_hold = 1'b0;
        wait (cycles > 3000);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (300) @(posedge clk);
        long_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        pixel_t want;
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: x=%0d y=%0d fault=%0b",
                             screen_x, screen_y, depth_fault);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (screen_x !== want.sx || screen_y !== want.sy ||
                    depth_fault !== want.fault)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected x=%0d y=%0d fault=%0b, %s",
                                 want.sx, want.sy, want.fault,
                                 $sformatf("got x=%0d y=%0d fault=%0b",
                                           screen_x, screen_y, depth_fault));
                end
            end
        end
    end

    initial
    begin
        cycles = 0;
        mismatches = 0;
        wait (sending_done && pending_pixels.size() == 0 || cycles > CYCLE_LIMIT);
        if (cycles <= CYCLE_LIMIT)
            repeat (2 * LATENCY) @(posedge clk);
        if (cycles <= CYCLE_LIMIT && mismatches == 0 && pending_pixels.size() == 0)
            $display("vertex_rotate_project_core_tb OK");
        else
            $display("vertex_rotate_project_core_tb NOT OK");
        $finish;
    end

endmodule
